>>> rtl/core/ocge_pkg.sv
// Package for the octant cell glyph encoder.
// Holds widths, the cell record passed from front to back, and the glyph table.
// No dependencies.
package ocge_pkg;

    localparam int LUMA_BITS     = 16;
    localparam int COLOR_W       = 8;
    localparam int SUM_W         = 11;
    localparam int CNT_W         = 4;
    localparam int GLYPH_W       = 17;
    localparam int CELL_SAMPLES  = 8;
    localparam int S_TDATA_W     = ((3 * COLOR_W + LUMA_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W     = ((GLYPH_W + 6 * COLOR_W + 7) / 8) * 8;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int SPECIAL_COUNT = 26;

    localparam logic [0:0] REG_LUMA_THRESHOLD = 1'b0;
    localparam logic [LUMA_BITS-1:0] THRESH_RESET = LUMA_BITS'(32768);
    localparam logic [GLYPH_W-1:0] OCTANT_BASE = 17'h1CD00;

    localparam logic [7:0] SPECIAL_MASK [SPECIAL_COUNT] = '{
        8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd10, 8'd15, 8'd20, 8'd40, 8'd63, 8'd64,
        8'd80, 8'd85, 8'd90, 8'd95, 8'd128, 8'd160, 8'd165, 8'd170, 8'd175,
        8'd192, 8'd240, 8'd245, 8'd250, 8'd252, 8'd255
    };

    localparam logic [GLYPH_W-1:0] SPECIAL_CODE [SPECIAL_COUNT] = '{
        17'h00020, 17'h1CEA8, 17'h1CEAB, 17'h1FB82, 17'h02598, 17'h0259D,
        17'h02580, 17'h1FBE6, 17'h1FBE7, 17'h1FB85, 17'h1CEA3, 17'h02596,
        17'h0258C, 17'h0259E, 17'h0259B, 17'h1CEA0, 17'h02597, 17'h0259A,
        17'h02590, 17'h0259C, 17'h02582, 17'h02584, 17'h02599, 17'h0259F,
        17'h02586, 17'h02588
    };

    typedef struct packed {
        logic [7:0]                mask;
        logic [2:0][SUM_W-1:0]     fg_sum;
        logic [2:0][SUM_W-1:0]     bg_sum;
    } t_cell;

    function automatic logic [GLYPH_W-1:0] glyph_for(input logic [7:0] mask);
        logic [4:0]         below;
        logic [GLYPH_W-1:0] code;
        logic               special;
        below   = '0;
        code    = '0;
        special = 1'b0;
        for (int i = 0; i < SPECIAL_COUNT; i++) begin
            if (SPECIAL_MASK[i] == mask) begin
                special = 1'b1;
                code    = SPECIAL_CODE[i];
            end
            if (SPECIAL_MASK[i] < mask) begin
                below = below + 5'd1;
            end
        end
        if (!special) begin
            code = OCTANT_BASE + GLYPH_W'(mask) - GLYPH_W'(below);
        end
        return code;
    endfunction

endpackage

>>> rtl/core/ocge_front.sv
// Front end of the octant cell glyph encoder: thresholds samples and accumulates a cell.
// Pushes one finished cell record per eight samples. Depends on ocge_pkg.
module ocge_front
    import ocge_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [LUMA_BITS-1:0] i_thresh,
    input  logic                 i_accept,
    input  logic [COLOR_W-1:0]   i_red,
    input  logic [COLOR_W-1:0]   i_green,
    input  logic [COLOR_W-1:0]   i_blue,
    input  logic [LUMA_BITS-1:0] i_luma,
    output logic                 o_push,
    output t_cell                o_cell
);

    logic [2:0]            r_pos;
    logic [7:0]            r_mask;
    logic [2:0][SUM_W-1:0] r_fg_sum;
    logic [2:0][SUM_W-1:0] r_bg_sum;
    logic [7:0]            n_mask;
    logic [2:0][SUM_W-1:0] n_fg_sum;
    logic [2:0][SUM_W-1:0] n_bg_sum;
    logic [2:0][COLOR_W-1:0] w_color;
    logic                  w_hit;
    logic                  w_last;

    assign w_color = {i_blue, i_green, i_red};
    assign w_hit   = (i_luma >= i_thresh);
    assign w_last  = (r_pos == 3'(CELL_SAMPLES - 1));

    always_comb begin
        n_mask   = r_mask;
        n_fg_sum = r_fg_sum;
        n_bg_sum = r_bg_sum;
        if (w_hit) begin
            n_mask[r_pos] = 1'b1;
        end
        for (int c = 0; c < 3; c++) begin
            if (w_hit) begin
                n_fg_sum[c] = r_fg_sum[c] + SUM_W'(w_color[c]);
            end else begin
                n_bg_sum[c] = r_bg_sum[c] + SUM_W'(w_color[c]);
            end
        end
    end

    assign o_push        = i_accept && w_last;
    assign o_cell.mask   = n_mask;
    assign o_cell.fg_sum = n_fg_sum;
    assign o_cell.bg_sum = n_bg_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_mask   <= '0;
            r_fg_sum <= '0;
            r_bg_sum <= '0;
        end else if (i_accept) begin
            if (w_last) begin
                r_pos    <= '0;
                r_mask   <= '0;
                r_fg_sum <= '0;
                r_bg_sum <= '0;
            end else begin
                r_pos    <= r_pos + 3'd1;
                r_mask   <= n_mask;
                r_fg_sum <= n_fg_sum;
                r_bg_sum <= n_bg_sum;
            end
        end
    end

endmodule

>>> rtl/core/ocge_queue.sv
// Two-entry queue of cell records between the front and back ends.
// Depends on ocge_pkg.
module ocge_queue
    import ocge_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cell i_cell,
    input  logic  i_pop,
    output t_cell o_cell,
    output logic  o_empty,
    output logic  o_full
);

    t_cell      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_cell  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/core/ocge_back.sv
// Back end of the octant cell glyph encoder: glyph lookup and six mean dividers.
// Divides two quotient bits per cycle and holds the result in an output register.
// Depends on ocge_pkg.
module ocge_back
    import ocge_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell                  i_cell,
    input  logic                   i_empty,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [GLYPH_W-1:0]     o_glyph,
    output logic [5:0][COLOR_W-1:0] o_mean
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state_e;

    t_state_e                r_state;
    logic [1:0]              r_step;
    logic [GLYPH_W-1:0]      r_glyph;
    logic [5:0][SUM_W-1:0]   r_rem;
    logic [5:0][COLOR_W-1:0] r_quo;
    logic [SUM_W-1:0]        r_dv_fg;
    logic [SUM_W-1:0]        r_dv_bg;
    logic                    r_fg_empty;
    logic                    r_bg_empty;
    logic                    r_out_valid;
    logic [GLYPH_W-1:0]      r_out_glyph;
    logic [5:0][COLOR_W-1:0] r_out_mean;
    logic [5:0][SUM_W-1:0]   n_rem;
    logic [5:0][COLOR_W-1:0] n_quo;
    logic [CNT_W-1:0]        w_nfg;
    logic [CNT_W-1:0]        w_nbg;
    logic                    w_load_out;

    always_comb begin
        w_nfg = '0;
        for (int b = 0; b < 8; b++) begin
            w_nfg = w_nfg + CNT_W'(i_cell.mask[b]);
        end
        w_nbg = CNT_W'(CELL_SAMPLES) - w_nfg;
    end

    always_comb begin
        logic [SUM_W-1:0] dv;
        logic [SUM_W-1:0] rem;
        logic             b1;
        logic             b0;
        for (int l = 0; l < 6; l++) begin
            dv  = (l < 3) ? r_dv_fg : r_dv_bg;
            rem = r_rem[l];
            b1  = (rem >= dv);
            if (b1) begin
                rem = rem - dv;
            end
            b0 = (rem >= (dv >> 1));
            if (b0) begin
                rem = rem - (dv >> 1);
            end
            n_rem[l] = rem;
            n_quo[l] = {r_quo[l][COLOR_W-3:0], b1, b0};
        end
    end

    assign o_pop      = (r_state == ST_IDLE) && !i_empty;
    assign w_load_out = (r_state == ST_DONE) && (!r_out_valid || i_ready);
    assign o_valid    = r_out_valid;
    assign o_glyph    = r_out_glyph;
    assign o_mean     = r_out_mean;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_state <= ST_DIV;
                        r_step  <= '0;
                    end
                end
                ST_DIV: begin
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
        if (o_pop) begin
            r_glyph    <= glyph_for(i_cell.mask);
            r_rem      <= {i_cell.bg_sum, i_cell.fg_sum};
            r_quo      <= '0;
            r_dv_fg    <= SUM_W'(w_nfg) << (COLOR_W - 1);
            r_dv_bg    <= SUM_W'(w_nbg) << (COLOR_W - 1);
            r_fg_empty <= (w_nfg == '0);
            r_bg_empty <= (w_nbg == '0);
        end else if (r_state == ST_DIV) begin
            r_rem   <= n_rem;
            r_quo   <= n_quo;
            r_dv_fg <= r_dv_fg >> 2;
            r_dv_bg <= r_dv_bg >> 2;
        end
        if (w_load_out) begin
            r_out_glyph <= r_glyph;
            for (int l = 0; l < 6; l++) begin
                if ((l < 3) ? r_fg_empty : r_bg_empty) begin
                    r_out_mean[l] <= '0;
                end else begin
                    r_out_mean[l] <= r_quo[l];
                end
            end
        end
    end

endmodule

>>> rtl/core/octant_cell_glyph_encoder.sv
// Top level of the octant cell glyph encoder: APB threshold register, front end,
// cell queue and back end. Depends on ocge_pkg, ocge_front, ocge_queue, ocge_back.
//
// The block takes one sub-sample per cycle when not held off, eight per 2x4
// character cell in row-major order, and gives one result per cell carrying
// the octant glyph codepoint and the mean foreground and background colours.
// The back end handles each cell in a load step, a divider that retires two
// quotient bits per cycle in all six color lanes, and a step into the output
// register, so with the two-entry cell queue the input is never held off
// while results are taken; the input waits only when the queue is full
// because results are not being taken. The luminance threshold is at byte
// address 0 and resets to 32768.
module octant_cell_glyph_encoder
    import ocge_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // Fields from bit 0 up: red, green, blue, luma.
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // Fields from bit 0 up: glyph, fg_red, fg_green, fg_blue, bg_red, bg_green,
    // bg_blue, zero padding.
    output logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    logic [LUMA_BITS-1:0]    r_thresh;
    logic                    w_cfg_wr;
    logic                    w_accept;
    logic                    w_push;
    logic                    w_pop;
    logic                    w_empty;
    logic                    w_full;
    t_cell                   w_push_cell;
    t_cell                   w_pop_cell;
    logic [GLYPH_W-1:0]      w_glyph;
    logic [5:0][COLOR_W-1:0] w_mean;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_LUMA_THRESHOLD) ? PDATA_W'(r_thresh) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (w_cfg_wr && (paddr[2] == REG_LUMA_THRESHOLD)) begin
            r_thresh <= pwdata[LUMA_BITS-1:0];
        end
    end

    assign o_s_axis_tready = !w_full;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    ocge_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_thresh (r_thresh),
        .i_accept (w_accept),
        .i_red    (i_s_axis_tdata[COLOR_W-1:0]),
        .i_green  (i_s_axis_tdata[2*COLOR_W-1:COLOR_W]),
        .i_blue   (i_s_axis_tdata[3*COLOR_W-1:2*COLOR_W]),
        .i_luma   (i_s_axis_tdata[3*COLOR_W +: LUMA_BITS]),
        .o_push   (w_push),
        .o_cell   (w_push_cell)
    );

    ocge_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cell  (w_push_cell),
        .i_pop   (w_pop),
        .o_cell  (w_pop_cell),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    ocge_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (w_pop_cell),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_glyph (w_glyph),
        .o_mean  (w_mean)
    );

    assign o_m_axis_tdata = {(M_TDATA_W - GLYPH_W - 6 * COLOR_W)'(0), w_mean, w_glyph};

endmodule

>>> rtl/core/ocge_checker.sv
// Port-level checker for the octant cell glyph encoder and its bind statement.
// Depends on ocge_pkg and octant_cell_glyph_encoder.
module ocge_checker
    import ocge_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    logic [GLYPH_W-1:0]   w_glyph;
    logic [3*COLOR_W-1:0] w_fg;
    logic [3*COLOR_W-1:0] w_bg;

    assign w_glyph = o_m_axis_tdata[GLYPH_W-1:0];
    assign w_fg    = o_m_axis_tdata[GLYPH_W +: 3 * COLOR_W];
    assign w_bg    = o_m_axis_tdata[GLYPH_W + 3 * COLOR_W +: 3 * COLOR_W];

    a_reset_no_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Output valid right after reset.");

    a_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("Stalled result changed or was dropped.");

    a_empty_fg_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_glyph == SPECIAL_CODE[0]) |-> (w_fg == '0))
        else $error("Blank cell has a non-black foreground.");

    a_empty_bg_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_glyph == SPECIAL_CODE[SPECIAL_COUNT-1]) |-> (w_bg == '0))
        else $error("Full cell has a non-black background.");

endmodule

bind octant_cell_glyph_encoder ocge_checker u_ocge_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for octant_cell_glyph_encoder: streams 2x4 cell samples,
// predicts glyph and mean colors per cell, and checks every output beat.
// Depends on ocge_pkg and the encoder RTL.
module tb;
    import ocge_pkg::*;

    localparam int LUMA_MAX   = (1 << LUMA_BITS) - 1;
    localparam int DRAIN_WAIT = 12;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;

    localparam logic [PADDR_W-1:0] ADDR_LUMA_THRESHOLD = PADDR_W'(0);
    localparam logic [PADDR_W-1:0] ADDR_UNUSED         = PADDR_W'(4);

    localparam logic [16:0] MOSAIC_BASE = 17'h1CD00;
    localparam logic [7:0] BLOCK_MASKS [26] = '{
        8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd10, 8'd15, 8'd20, 8'd40, 8'd63, 8'd64,
        8'd80, 8'd85, 8'd90, 8'd95, 8'd128, 8'd160, 8'd165, 8'd170, 8'd175,
        8'd192, 8'd240, 8'd245, 8'd250, 8'd252, 8'd255
    };
    localparam logic [16:0] BLOCK_CODES [26] = '{
        17'h00020, 17'h1CEA8, 17'h1CEAB, 17'h1FB82, 17'h02598, 17'h0259D,
        17'h02580, 17'h1FBE6, 17'h1FBE7, 17'h1FB85, 17'h1CEA3, 17'h02596,
        17'h0258C, 17'h0259E, 17'h0259B, 17'h1CEA0, 17'h02597, 17'h0259A,
        17'h02590, 17'h0259C, 17'h02582, 17'h02584, 17'h02599, 17'h0259F,
        17'h02586, 17'h02588
    };

    typedef struct packed {
        logic [LUMA_BITS-1:0] luma;
        logic [COLOR_W-1:0]   blue;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   red;
    } t_pixel;

    typedef struct packed {
        logic [COLOR_W-1:0] bg_blue;
        logic [COLOR_W-1:0] bg_green;
        logic [COLOR_W-1:0] bg_red;
        logic [COLOR_W-1:0] fg_blue;
        logic [COLOR_W-1:0] fg_green;
        logic [COLOR_W-1:0] fg_red;
        logic [16:0]        glyph;
    } t_glyph_result;

    localparam int RESULT_W = $bits(t_glyph_result);

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    // Fields from bit 0 up: red, green, blue, luma.
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // Fields from bit 0 up: glyph, fg_red, fg_green, fg_blue, bg_red, bg_green,
    // bg_blue, zero padding.
    logic [M_TDATA_W-1:0] o_m_axis_tdata;

    octant_cell_glyph_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_left = 0;
    int unsigned errors = 0;
    int unsigned samples_taken = 0;
    int unsigned glyphs_checked = 0;
    int unsigned quiet_cycles = 0;
    logic [LUMA_BITS-1:0] gen_threshold = THRESH_RESET;

    // Predicted state of the cell accumulator.
    logic [LUMA_BITS-1:0] model_threshold = THRESH_RESET;
    logic [2:0]           acc_pos = '0;
    logic [7:0]           acc_mask = '0;
    logic [SUM_W-1:0]     fg_r = '0, fg_g = '0, fg_b = '0;
    logic [SUM_W-1:0]     bg_r = '0, bg_g = '0, bg_b = '0;
    t_glyph_result        pending_glyphs[$];
    bit                   masks_seen [256];

    function automatic logic [16:0] glyph_of_mask(input logic [7:0] mask);
        int unsigned below;
        below = 0;
        for (int i = 0; i < 26; i++) begin
            if (BLOCK_MASKS[i] == mask) return BLOCK_CODES[i];
            if (BLOCK_MASKS[i] < mask) below++;
        end
        return MOSAIC_BASE + 17'(mask) - 17'(below);
    endfunction

    function automatic logic [COLOR_W-1:0] mean_of(input logic [SUM_W-1:0] sum,
                                                    input int unsigned n);
        if (n == 0) return '0;
        return COLOR_W'(sum / n);
    endfunction

    task automatic absorb_pixel(input t_pixel p);
        t_glyph_result r;
        int unsigned   lit;
        if (p.luma >= model_threshold) begin
            acc_mask[acc_pos] = 1'b1;
            fg_r += p.red;
            fg_g += p.green;
            fg_b += p.blue;
        end else begin
            bg_r += p.red;
            bg_g += p.green;
            bg_b += p.blue;
        end
        if (acc_pos == 3'd7) begin
            lit        = $countones(acc_mask);
            r.glyph    = glyph_of_mask(acc_mask);
            r.fg_red   = mean_of(fg_r, lit);
            r.fg_green = mean_of(fg_g, lit);
            r.fg_blue  = mean_of(fg_b, lit);
            r.bg_red   = mean_of(bg_r, 8 - lit);
            r.bg_green = mean_of(bg_g, 8 - lit);
            r.bg_blue  = mean_of(bg_b, 8 - lit);
            pending_glyphs.push_back(r);
            masks_seen[acc_mask] = 1'b1;
            acc_pos  = '0;
            acc_mask = '0;
            fg_r = '0; fg_g = '0; fg_b = '0;
            bg_r = '0; bg_g = '0; bg_b = '0;
        end else begin
            acc_pos = acc_pos + 3'd1;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_glyph_beat(input logic [M_TDATA_W-1:0] beat);
        t_glyph_result want;
        t_glyph_result got;
        got = t_glyph_result'(beat[RESULT_W-1:0]);
        if (pending_glyphs.size() == 0) begin
            $display("%0t: unexpected output beat, expected none, actual %h", $time, beat);
            errors++;
        end else begin
            want = pending_glyphs.pop_front();
            check_field("glyph", want.glyph, got.glyph);
            check_field("fg_red", want.fg_red, got.fg_red);
            check_field("fg_green", want.fg_green, got.fg_green);
            check_field("fg_blue", want.fg_blue, got.fg_blue);
            check_field("bg_red", want.bg_red, got.bg_red);
            check_field("bg_green", want.bg_green, got.bg_green);
            check_field("bg_blue", want.bg_blue, got.bg_blue);
            check_field("padding", 0, beat[M_TDATA_W-1:RESULT_W]);
            glyphs_checked++;
        end
    endtask

    // Checks output beats, follows input beats and register writes, and guards
    // against a hung pipeline.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                check_glyph_beat(o_m_axis_tdata);
                quiet_cycles = 0;
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_LUMA_THRESHOLD) begin
                model_threshold = pwdata[LUMA_BITS-1:0];
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                absorb_pixel(t_pixel'(i_s_axis_tdata));
                samples_taken++;
                quiet_cycles = 0;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    task automatic send_sample(input t_pixel p);
        logic ready_seen;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= p;
        do begin
            @(negedge i_clk);
            ready_seen = o_s_axis_tready;
            @(posedge i_clk);
        end while (!ready_seen);
    endtask

    task automatic stop_stream();
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
    endtask

    task automatic wait_drain();
        while (pending_glyphs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        logic ready_seen;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            ready_seen = pready;
            @(posedge i_clk);
        end while (!ready_seen);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_LUMA_THRESHOLD) gen_threshold = data[LUMA_BITS-1:0];
    endtask

    task automatic apb_read_check(input logic [PADDR_W-1:0] addr,
                                  input logic [PDATA_W-1:0] want);
        logic ready_seen;
        logic [PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            ready_seen = pready;
            got        = prdata;
            @(posedge i_clk);
        end while (!ready_seen);
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("luma_threshold readback", want, got);
    endtask

    function automatic logic [COLOR_W-1:0] random_color();
        if ($urandom_range(7, 0) == 0) return $urandom_range(1, 0) ? 8'hFF : 8'h00;
        return COLOR_W'($urandom);
    endfunction

    function automatic logic [LUMA_BITS-1:0] pick_luma(input bit lit);
        int unsigned t;
        t = gen_threshold;
        if (lit || t == 0) begin
            if ($urandom_range(3, 0) == 0) return LUMA_BITS'(t);
            return LUMA_BITS'($urandom_range(LUMA_MAX, t));
        end
        if ($urandom_range(3, 0) == 0) return LUMA_BITS'(t - 1);
        return LUMA_BITS'($urandom_range(t - 1, 0));
    endfunction

    // Most cells follow a random mask with luma placed on the proper side of
    // the threshold; some cells carry unstructured luma.
    task automatic send_random_cell();
        logic [7:0] bits;
        bit         noisy;
        t_pixel     p;
        bits  = 8'($urandom);
        noisy = ($urandom_range(7, 0) == 0);
        for (int i = 0; i < 8; i++) begin
            p.red   = random_color();
            p.green = random_color();
            p.blue  = random_color();
            p.luma  = noisy ? LUMA_BITS'($urandom) : pick_luma(bits[i]);
            send_sample(p);
        end
    endtask

    task automatic test_register_access();
        apb_read_check(ADDR_LUMA_THRESHOLD, PDATA_W'(THRESH_RESET));
        apb_write(ADDR_LUMA_THRESHOLD, 32'hABCD_1234);
        apb_read_check(ADDR_LUMA_THRESHOLD, 32'h0000_1234);
        apb_write(ADDR_UNUSED, 32'h0000_0000);
        apb_read_check(ADDR_LUMA_THRESHOLD, 32'h0000_1234);
        apb_write(ADDR_LUMA_THRESHOLD, PDATA_W'(THRESH_RESET));
    endtask

    task automatic test_empty_foreground();
        t_pixel p;
        for (int i = 0; i < 8; i++) begin
            p.red   = 8'hFF;
            p.green = COLOR_W'(i * 31);
            p.blue  = 8'h00;
            p.luma  = (i == 7) ? LUMA_BITS'(THRESH_RESET - 1) : LUMA_BITS'(i * 1000);
            send_sample(p);
        end
        stop_stream();
        wait_drain();
    endtask

    task automatic test_empty_background();
        t_pixel p;
        for (int i = 0; i < 8; i++) begin
            p.red   = 8'h00;
            p.green = 8'hFF;
            p.blue  = COLOR_W'(i * 37);
            p.luma  = i[0] ? LUMA_BITS'(LUMA_MAX) : THRESH_RESET;
            send_sample(p);
        end
        stop_stream();
        wait_drain();
    endtask

    task automatic test_threshold_mid_cell();
        t_pixel p;
        for (int i = 0; i < 8; i++) begin
            if (i == 4) begin
                stop_stream();
                wait_drain();
                apb_write(ADDR_LUMA_THRESHOLD, 32'hFFFF_FFFF);
            end
            p.red   = COLOR_W'(i * 29 + 3);
            p.green = COLOR_W'(255 - i * 13);
            p.blue  = i[0] ? 8'hFF : 8'h00;
            case (i)
                0:       p.luma = THRESH_RESET;
                1:       p.luma = LUMA_BITS'(THRESH_RESET - 1);
                4, 7:    p.luma = LUMA_BITS'(LUMA_MAX);
                5, 6:    p.luma = LUMA_BITS'(LUMA_MAX - 1);
                default: p.luma = 16'hC000;
            endcase
            send_sample(p);
        end
        stop_stream();
        wait_drain();
    endtask

    task automatic test_random_traffic(input int unsigned s_idle, input int unsigned r_idle);
        logic [LUMA_BITS-1:0] thr;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int chunk = 0; chunk < 4; chunk++) begin
            case (chunk)
                1:       thr = '0;
                2:       thr = LUMA_BITS'(LUMA_MAX);
                default: thr = LUMA_BITS'($urandom);
            endcase
            apb_write(ADDR_LUMA_THRESHOLD, {16'($urandom), thr});
            for (int n = 0; n < 15; n++) send_random_cell();
            stop_stream();
            wait_drain();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apb_write(ADDR_LUMA_THRESHOLD, PDATA_W'($urandom_range(LUMA_MAX, 1)));
        @(negedge i_clk);
        hold_left = HOLD_CYCLES;
        @(posedge i_clk);
        for (int n = 0; n < 12; n++) send_random_cell();
        stop_stream();
        wait_drain();
    endtask

    initial begin
        int unsigned mask_count;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_empty_foreground();
        test_empty_background();
        test_threshold_mid_cell();
        test_random_traffic(20, 66);
        test_random_traffic(66, 20);
        test_random_traffic(0, 0);
        test_backpressure();
        wait_drain();

        mask_count = 0;
        for (int m = 0; m < 256; m++) mask_count += masks_seen[m];
        $display("Summary: %0d samples streamed, %0d glyph beats checked, %0d of 256 masks hit.",
                 samples_taken, glyphs_checked, mask_count);
        $display("Thresholds spanned 0 to full scale, with stalls on both sides of the stream.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
